// ===== sv/triangle_circumcenter_core_defines.svh =====
// Assertion macros for the triangle circumcenter core.
`ifndef TRIANGLE_CIRCUMCENTER_CORE_DEFINES_SVH
`define TRIANGLE_CIRCUMCENTER_CORE_DEFINES_SVH
`ifndef SYNTH
`define TCC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("tcc: assertion failed");
`define TCC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tcc: implication failed");
`else
`define TCC_ASSERT(lbl, prop)
`define TCC_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

// ===== sv/tcc_pkg.sv =====
// Widths, types and status codes shared by the circumcenter core.
`default_nettype none
package tcc_pkg;

  localparam int unsigned COORD_W    = 24;
  localparam int unsigned DIFF_W     = COORD_W + 1;
  localparam int unsigned SQ_W       = 2 * DIFF_W;
  localparam int unsigned LEN_W      = 2 * DIFF_W;
  localparam int unsigned PP_W       = 2 * DIFF_W + 1;
  localparam int unsigned NUM_W      = 3 * COORD_W + 4;
  localparam int unsigned DEN_W      = SQ_W + 1;
  localparam int unsigned Q_W        = 41;
  localparam int unsigned REM_W      = DEN_W + Q_W;
  localparam int unsigned OUT_W      = 32;
  localparam int unsigned PLACE_W    = ((Q_W > COORD_W) ? Q_W : COORD_W) + 2;
  localparam int unsigned IN_DATA_W  = ((6 * COORD_W + 7) / 8) * 8;
  localparam int unsigned OUT_DATA_W = 2 * OUT_W;
  localparam int unsigned STAT_W     = 2;

  typedef enum logic [STAT_W-1:0] {
    ST_VALID     = 2'd0,
    ST_COLLINEAR = 2'd1,
    ST_SATURATED = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] ax;
    logic signed [COORD_W-1:0] ay;
    logic signed [COORD_W-1:0] bx;
    logic signed [COORD_W-1:0] by;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
  } tri_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] ax;
    logic signed [COORD_W-1:0] ay;
    logic signed [DIFF_W-1:0]  dx;
    logic signed [DIFF_W-1:0]  dy;
    logic signed [DIFF_W-1:0]  ex;
    logic signed [DIFF_W-1:0]  ey;
    logic [LEN_W-1:0]          bl;
    logic [LEN_W-1:0]          cl;
    logic signed [SQ_W-1:0]    d;
  } front_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] ax;
    logic signed [COORD_W-1:0] ay;
    logic                      d_zero;
    logic                      nx_neg;
    logic                      ny_neg;
    logic                      ovf_x;
    logic                      ovf_y;
    logic [DEN_W-1:0]          den;
    logic [REM_W-1:0]          rem_x;
    logic [REM_W-1:0]          rem_y;
    logic [Q_W-1:0]            qx;
    logic [Q_W-1:0]            qy;
  } div_t;

  typedef struct packed {
    logic [OUT_W-1:0] cx;
    logic [OUT_W-1:0] cy;
    status_e          status;
  } out_t;

endpackage
`default_nettype wire

// ===== sv/triangle_circumcenter_core.sv =====
// Circumcenter of a 2D triangle: pipeline, final placement and output buffer.
// Usage:
//  - s_axis carries one triangle per word: six signed coordinates, 24 bits each.
//  - m_axis returns one word per triangle, in order: centre x, centre y and a
//    status in tuser (valid, collinear with first vertex returned, saturated).
//  - Fully pipelined: a new triangle can be taken every cycle while the skid register is empty.
//  - Pipeline: 3 stages geometry, 6 stages numerators, 41 divider stages,
//    then the output register.
//  - The divider retires one quotient bit per stage; its 41 stages make up most
//    of the latency.
//  - When the receiver stalls, one more result is caught in a skid register
//    and then the whole pipeline holds; s_axis_tready drops while the skid
//    register is full. Nothing is dropped or repeated.
//  - Reset clears all valid bits; payload registers are not reset.
`default_nettype none
`include "triangle_circumcenter_core_defines.svh"
module triangle_circumcenter_core (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // a_x, a_y, b_x, b_y, c_x, c_y
  input  wire logic [tcc_pkg::IN_DATA_W-1:0]    s_axis_tdata_i,
  output logic                                  m_axis_tvalid_o,
  input  wire logic                             m_axis_tready_i,
  // center_x, center_y
  output logic [tcc_pkg::OUT_DATA_W-1:0]        m_axis_tdata_o,
  // status
  output logic [tcc_pkg::STAT_W-1:0]            m_axis_tuser_o
);
  import tcc_pkg::*;

  localparam logic signed [PLACE_W-1:0] LimHi =
    PLACE_W'((64'sd1 <<< (OUT_W - 1)) - 64'sd1);
  localparam logic signed [PLACE_W-1:0] LimLo = -LimHi - PLACE_W'(1);
  localparam logic [OUT_W-1:0] SatHi = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] SatLo = {1'b1, {(OUT_W-1){1'b0}}};

  typedef struct packed {
    logic [OUT_W-1:0] value;
    logic             sat;
  } coord_res_t;

  function automatic coord_res_t place(input logic signed [COORD_W-1:0] base,
                                       input logic neg, input logic [Q_W-1:0] q,
                                       input logic ovf);
    coord_res_t                 r;
    logic signed [PLACE_W-1:0]  qs;
    logic signed [PLACE_W-1:0]  sum;
    qs  = $signed(PLACE_W'(q));
    sum = neg ? (PLACE_W'(base) - qs) : (PLACE_W'(base) + qs);
    r.sat = 1'b1;
    if (ovf) begin
      r.value = neg ? SatLo : SatHi;
    end else if (sum > LimHi) begin
      r.value = SatHi;
    end else if (sum < LimLo) begin
      r.value = SatLo;
    end else begin
      r.value = sum[OUT_W-1:0];
      r.sat   = 1'b0;
    end
    return r;
  endfunction

  logic       en;
  tri_t       tri_in;
  logic       front_v, numer_v, div_v;
  front_t     front_d;
  div_t       numer_d, div_d;
  coord_res_t px, py;
  out_t       res;
  out_t       out_q, out_d, skid_q, skid_d;
  logic       out_v_q, out_v_d, skid_v_q, skid_v_d;
  logic       out_at_lim;

  // the pipeline moves as one while the skid register is free
  assign en              = !skid_v_q;
  assign s_axis_tready_o = en;

  assign tri_in.ax = s_axis_tdata_i[0*COORD_W +: COORD_W];
  assign tri_in.ay = s_axis_tdata_i[1*COORD_W +: COORD_W];
  assign tri_in.bx = s_axis_tdata_i[2*COORD_W +: COORD_W];
  assign tri_in.by = s_axis_tdata_i[3*COORD_W +: COORD_W];
  assign tri_in.cx = s_axis_tdata_i[4*COORD_W +: COORD_W];
  assign tri_in.cy = s_axis_tdata_i[5*COORD_W +: COORD_W];

  tcc_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid_i),
    .tri_i   (tri_in),
    .valid_o (front_v),
    .data_o  (front_d)
  );

  tcc_numer u_numer (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (front_v),
    .data_i  (front_d),
    .valid_o (numer_v),
    .data_o  (numer_d)
  );

  tcc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (numer_v),
    .data_i  (numer_d),
    .valid_o (div_v),
    .data_o  (div_d)
  );

  always_comb begin
    px = place(div_d.ax, div_d.nx_neg, div_d.qx, div_d.ovf_x);
    py = place(div_d.ay, div_d.ny_neg, div_d.qy, div_d.ovf_y);
    if (div_d.d_zero) begin
      res.cx     = OUT_W'(div_d.ax);
      res.cy     = OUT_W'(div_d.ay);
      res.status = ST_COLLINEAR;
    end else begin
      res.cx     = px.value;
      res.cy     = py.value;
      res.status = (px.sat || py.sat) ? ST_SATURATED : ST_VALID;
    end
  end

  always_comb begin
    out_d    = out_q;
    out_v_d  = out_v_q;
    skid_d   = skid_q;
    skid_v_d = skid_v_q;
    if (!out_v_q || m_axis_tready_i) begin
      if (skid_v_q) begin
        out_d    = skid_q;
        out_v_d  = 1'b1;
        skid_v_d = 1'b0;
      end else begin
        out_d    = res;
        out_v_d  = div_v;
      end
    end else if (en && div_v) begin
      skid_d   = res;
      skid_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = {out_q.cy, out_q.cx};
  assign m_axis_tuser_o  = out_q.status;

  assign out_at_lim = (out_q.cx == SatHi) || (out_q.cx == SatLo) ||
                      (out_q.cy == SatHi) || (out_q.cy == SatLo);

  `TCC_ASSERT_IMP(a_skid_behind_out, skid_v_q, out_v_q)
  `TCC_ASSERT_IMP(a_skid_blocks_input, skid_v_q, !s_axis_tready_o)
  `TCC_ASSERT_IMP(a_sat_at_limit, out_v_q && (out_q.status == ST_SATURATED), out_at_lim)

endmodule
`default_nettype wire

// ===== sv/tcc_front.sv =====
// Edge vectors, squared lengths and cross product, three stages.
`default_nettype none
module tcc_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           en_i,
  input  wire logic           valid_i,
  input  wire tcc_pkg::tri_t  tri_i,
  output logic                valid_o,
  output tcc_pkg::front_t     data_o
);
  import tcc_pkg::*;

  // stage 1: edges
  logic                      v1_q;
  logic signed [COORD_W-1:0] ax1_q, ay1_q;
  logic signed [DIFF_W-1:0]  dx1_q, dy1_q, ex1_q, ey1_q;
  logic signed [DIFF_W-1:0]  dx1_d, dy1_d, ex1_d, ey1_d;
  // stage 2: products
  logic                      v2_q;
  logic signed [COORD_W-1:0] ax2_q, ay2_q;
  logic signed [DIFF_W-1:0]  dx2_q, dy2_q, ex2_q, ey2_q;
  logic signed [SQ_W-1:0]    sdx_q, sdy_q, sex_q, sey_q, pde_q, pdx_q;
  logic signed [SQ_W-1:0]    sdx_d, sdy_d, sex_d, sey_d, pde_d, pdx_d;
  // stage 3: sums
  logic                      v3_q;
  front_t                    f3_q, f3_d;

  assign dx1_d = DIFF_W'(tri_i.bx) - DIFF_W'(tri_i.ax);
  assign dy1_d = DIFF_W'(tri_i.by) - DIFF_W'(tri_i.ay);
  assign ex1_d = DIFF_W'(tri_i.cx) - DIFF_W'(tri_i.ax);
  assign ey1_d = DIFF_W'(tri_i.cy) - DIFF_W'(tri_i.ay);

  assign sdx_d = dx1_q * dx1_q;
  assign sdy_d = dy1_q * dy1_q;
  assign sex_d = ex1_q * ex1_q;
  assign sey_d = ey1_q * ey1_q;
  assign pde_d = dx1_q * ey1_q;
  assign pdx_d = dy1_q * ex1_q;

  always_comb begin
    f3_d    = '0;
    f3_d.ax = ax2_q;
    f3_d.ay = ay2_q;
    f3_d.dx = dx2_q;
    f3_d.dy = dy2_q;
    f3_d.ex = ex2_q;
    f3_d.ey = ey2_q;
    f3_d.bl = $unsigned(sdx_q) + $unsigned(sdy_q);
    f3_d.cl = $unsigned(sex_q) + $unsigned(sey_q);
    f3_d.d  = pde_q - pdx_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ax1_q <= tri_i.ax;
      ay1_q <= tri_i.ay;
      dx1_q <= dx1_d;
      dy1_q <= dy1_d;
      ex1_q <= ex1_d;
      ey1_q <= ey1_d;
      ax2_q <= ax1_q;
      ay2_q <= ay1_q;
      dx2_q <= dx1_q;
      dy2_q <= dy1_q;
      ex2_q <= ex1_q;
      ey2_q <= ey1_q;
      sdx_q <= sdx_d;
      sdy_q <= sdy_d;
      sex_q <= sex_d;
      sey_q <= sey_d;
      pde_q <= pde_d;
      pdx_q <= pdx_d;
      f3_q  <= f3_d;
    end
  end

  assign valid_o = v3_q;
  assign data_o  = f3_q;

endmodule
`default_nettype wire

// ===== sv/tcc_numer.sv =====
// Numerators, divisor and range check, six stages.
`default_nettype none
module tcc_numer (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire logic            valid_i,
  input  wire tcc_pkg::front_t data_i,
  output logic                 valid_o,
  output tcc_pkg::div_t        data_o
);
  import tcc_pkg::*;

  logic [5:0] v_q;

  // stage 4: partial products, bl and cl split in halves
  logic signed [COORD_W-1:0] ax4_q, ay4_q;
  logic signed [PP_W-1:0]    eybl_lo_q, eybl_hi_q, dycl_lo_q, dycl_hi_q;
  logic signed [PP_W-1:0]    dxcl_lo_q, dxcl_hi_q, exbl_lo_q, exbl_hi_q;
  logic signed [PP_W-1:0]    eybl_lo_d, eybl_hi_d, dycl_lo_d, dycl_hi_d;
  logic signed [PP_W-1:0]    dxcl_lo_d, dxcl_hi_d, exbl_lo_d, exbl_hi_d;
  logic signed [DIFF_W:0]    bl_lo, bl_hi, cl_lo, cl_hi;
  logic [SQ_W-1:0]           dm4_q, dm4_d;
  logic                      dneg4_q, dzero4_q;
  // stage 5: full products
  logic signed [COORD_W-1:0] ax5_q, ay5_q;
  logic signed [NUM_W-1:0]   eybl_q, dycl_q, dxcl_q, exbl_q;
  logic signed [NUM_W-1:0]   eybl_d, dycl_d, dxcl_d, exbl_d;
  logic [SQ_W-1:0]           dm5_q;
  logic                      dneg5_q, dzero5_q;
  // stage 6: numerators, sign folded for negative d
  logic signed [COORD_W-1:0] ax6_q, ay6_q;
  logic signed [NUM_W-1:0]   nx6_q, ny6_q, nx6_d, ny6_d;
  logic [SQ_W-1:0]           dm6_q;
  logic                      dzero6_q;
  // stage 7: magnitudes
  logic signed [COORD_W-1:0] ax7_q, ay7_q;
  logic [NUM_W-1:0]          nxm7_q, nym7_q;
  logic                      nxneg7_q, nyneg7_q, dzero7_q;
  logic [SQ_W-1:0]           dm7_q;
  // stage 8: rounded dividend, divisor, overflow limit
  logic signed [COORD_W-1:0] ax8_q, ay8_q;
  logic [NUM_W-1:0]          nnx8_q, nny8_q;
  logic [DEN_W-1:0]          den8_q, den8_d;
  logic [REM_W-1:0]          lim8_q;
  logic                      nxneg8_q, nyneg8_q, dzero8_q;
  // stage 9
  div_t                      d9_q, d9_d;

  assign bl_lo = $signed({1'b0, data_i.bl[DIFF_W-1:0]});
  assign bl_hi = $signed({1'b0, data_i.bl[LEN_W-1:DIFF_W]});
  assign cl_lo = $signed({1'b0, data_i.cl[DIFF_W-1:0]});
  assign cl_hi = $signed({1'b0, data_i.cl[LEN_W-1:DIFF_W]});

  assign eybl_lo_d = $signed(data_i.ey) * bl_lo;
  assign eybl_hi_d = $signed(data_i.ey) * bl_hi;
  assign dycl_lo_d = $signed(data_i.dy) * cl_lo;
  assign dycl_hi_d = $signed(data_i.dy) * cl_hi;
  assign dxcl_lo_d = $signed(data_i.dx) * cl_lo;
  assign dxcl_hi_d = $signed(data_i.dx) * cl_hi;
  assign exbl_lo_d = $signed(data_i.ex) * bl_lo;
  assign exbl_hi_d = $signed(data_i.ex) * bl_hi;
  assign dm4_d = data_i.d[SQ_W-1] ? $unsigned(-$signed(data_i.d)) : $unsigned(data_i.d);

  assign eybl_d = (NUM_W'(eybl_hi_q) <<< DIFF_W) + NUM_W'(eybl_lo_q);
  assign dycl_d = (NUM_W'(dycl_hi_q) <<< DIFF_W) + NUM_W'(dycl_lo_q);
  assign dxcl_d = (NUM_W'(dxcl_hi_q) <<< DIFF_W) + NUM_W'(dxcl_lo_q);
  assign exbl_d = (NUM_W'(exbl_hi_q) <<< DIFF_W) + NUM_W'(exbl_lo_q);

  assign nx6_d = dneg5_q ? (dycl_q - eybl_q) : (eybl_q - dycl_q);
  assign ny6_d = dneg5_q ? (exbl_q - dxcl_q) : (dxcl_q - exbl_q);

  assign den8_d = {dm7_q, 1'b0};

  always_comb begin
    d9_d        = '0;
    d9_d.ax     = ax8_q;
    d9_d.ay     = ay8_q;
    d9_d.d_zero = dzero8_q;
    d9_d.nx_neg = nxneg8_q;
    d9_d.ny_neg = nyneg8_q;
    d9_d.den    = den8_q;
    d9_d.rem_x  = REM_W'(nnx8_q);
    d9_d.rem_y  = REM_W'(nny8_q);
    // quotient above 2^40 saturates
    d9_d.ovf_x  = REM_W'(nnx8_q) >= lim8_q;
    d9_d.ovf_y  = REM_W'(nny8_q) >= lim8_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[4:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ax4_q     <= data_i.ax;
      ay4_q     <= data_i.ay;
      eybl_lo_q <= eybl_lo_d;
      eybl_hi_q <= eybl_hi_d;
      dycl_lo_q <= dycl_lo_d;
      dycl_hi_q <= dycl_hi_d;
      dxcl_lo_q <= dxcl_lo_d;
      dxcl_hi_q <= dxcl_hi_d;
      exbl_lo_q <= exbl_lo_d;
      exbl_hi_q <= exbl_hi_d;
      dm4_q     <= dm4_d;
      dneg4_q   <= data_i.d[SQ_W-1];
      dzero4_q  <= (data_i.d == '0);

      ax5_q     <= ax4_q;
      ay5_q     <= ay4_q;
      eybl_q    <= eybl_d;
      dycl_q    <= dycl_d;
      dxcl_q    <= dxcl_d;
      exbl_q    <= exbl_d;
      dm5_q     <= dm4_q;
      dneg5_q   <= dneg4_q;
      dzero5_q  <= dzero4_q;

      ax6_q     <= ax5_q;
      ay6_q     <= ay5_q;
      nx6_q     <= nx6_d;
      ny6_q     <= ny6_d;
      dm6_q     <= dm5_q;
      dzero6_q  <= dzero5_q;

      ax7_q     <= ax6_q;
      ay7_q     <= ay6_q;
      nxneg7_q  <= nx6_q[NUM_W-1];
      nyneg7_q  <= ny6_q[NUM_W-1];
      nxm7_q    <= nx6_q[NUM_W-1] ? $unsigned(-nx6_q) : $unsigned(nx6_q);
      nym7_q    <= ny6_q[NUM_W-1] ? $unsigned(-ny6_q) : $unsigned(ny6_q);
      dm7_q     <= dm6_q;
      dzero7_q  <= dzero6_q;

      ax8_q     <= ax7_q;
      ay8_q     <= ay7_q;
      nnx8_q    <= nxm7_q + NUM_W'(dm7_q);
      nny8_q    <= nym7_q + NUM_W'(dm7_q);
      den8_q    <= den8_d;
      lim8_q    <= (REM_W'(den8_d) << (Q_W - 1)) + REM_W'(den8_d);
      nxneg8_q  <= nxneg7_q;
      nyneg8_q  <= nyneg7_q;
      dzero8_q  <= dzero7_q;

      d9_q      <= d9_d;
    end
  end

  assign valid_o = v_q[5];
  assign data_o  = d9_q;

endmodule
`default_nettype wire

// ===== sv/tcc_div.sv =====
// Restoring divider, one quotient bit per stage for both coordinates.
`default_nettype none
module tcc_div (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          valid_i,
  input  wire tcc_pkg::div_t data_i,
  output logic               valid_o,
  output tcc_pkg::div_t      data_o
);
  import tcc_pkg::*;

  logic v_q   [Q_W];
  div_t stg_q [Q_W];

  for (genvar k = 0; k < Q_W; k++) begin : g_step
    localparam int unsigned Bit = Q_W - 1 - k;
    div_t             cur, nxt;
    logic             cur_v;
    logic [REM_W-1:0] sh;

    if (k == 0) begin : g_first
      assign cur   = data_i;
      assign cur_v = valid_i;
    end else begin : g_rest
      assign cur   = stg_q[k-1];
      assign cur_v = v_q[k-1];
    end

    assign sh = REM_W'(cur.den) << Bit;

    always_comb begin
      nxt = cur;
      if (cur.rem_x >= sh) begin
        nxt.rem_x   = cur.rem_x - sh;
        nxt.qx[Bit] = 1'b1;
      end
      if (cur.rem_y >= sh) begin
        nxt.rem_y   = cur.rem_y - sh;
        nxt.qy[Bit] = 1'b1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= cur_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        stg_q[k] <= nxt;
      end
    end
  end

  assign valid_o = v_q[Q_W-1];
  assign data_o  = stg_q[Q_W-1];

endmodule
`default_nettype wire

// ===== test/tcc_centre_checker.sv =====
// Checker for the circumcentre core: predicts each centre and compares results in order.
`timescale 1ns / 100ps
`default_nettype none
module tcc_centre_checker (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid_i,
  input  wire logic                          s_axis_tready_i,
  input  wire logic [tcc_pkg::IN_DATA_W-1:0] s_axis_tdata_i,
  input  wire logic                          m_axis_tvalid_i,
  input  wire logic                          m_axis_tready_i,
  input  wire logic [tcc_pkg::OUT_DATA_W-1:0] m_axis_tdata_i,
  input  wire logic [tcc_pkg::STAT_W-1:0]    m_axis_tuser_i,
  output int                                 mismatches_o,
  output int                                 pending_o
);
  import tcc_pkg::*;

  typedef struct packed {
    logic [31:0] cx;
    logic [31:0] cy;
    status_e     st;
  } centre_t;

  typedef logic signed [159:0] wide_s;
  typedef logic [159:0]        wide_u;

  localparam wide_s OUT_MAX = (wide_s'(1) <<< 31) - wide_s'(1);
  localparam wide_s OUT_MIN = -(wide_s'(1) <<< 31);

  centre_t centre_q[$];

  // vertex coordinate plus offset num/(2*den), rounded half away from zero, clamped
  function automatic logic [31:0] place_axis(input wide_s base, input wide_s num,
                                             input wide_u den, output logic sat);
    wide_u mag;
    wide_u q;
    wide_s v;
    sat = 1'b0;
    mag = (num < 0) ? wide_u'(-num) : wide_u'(num);
    q   = (mag + den) / (den << 1);
    if (q > (wide_u'(1) << 40)) begin
      sat = 1'b1;
      return (num < 0) ? 32'h8000_0000 : 32'h7fff_ffff;
    end
    v = (num < 0) ? base - wide_s'(q) : base + wide_s'(q);
    if (v > OUT_MAX) begin
      sat = 1'b1;
      return 32'h7fff_ffff;
    end
    if (v < OUT_MIN) begin
      sat = 1'b1;
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic centre_t predict_centre(input logic [IN_DATA_W-1:0] w);
    wide_s ax, ay, dx, dy, ex, ey, bl, cl, d, nx, ny;
    logic  sat_x, sat_y;
    centre_t r;
    ax = $signed(w[0*COORD_W +: COORD_W]);
    ay = $signed(w[1*COORD_W +: COORD_W]);
    dx = wide_s'($signed(w[2*COORD_W +: COORD_W])) - ax;
    dy = wide_s'($signed(w[3*COORD_W +: COORD_W])) - ay;
    ex = wide_s'($signed(w[4*COORD_W +: COORD_W])) - ax;
    ey = wide_s'($signed(w[5*COORD_W +: COORD_W])) - ay;
    bl = dx * dx + dy * dy;
    cl = ex * ex + ey * ey;
    d  = dx * ey - dy * ex;
    if (d == 0) begin
      r.cx = ax[31:0];
      r.cy = ay[31:0];
      r.st = ST_COLLINEAR;
      return r;
    end
    nx = ey * bl - dy * cl;
    ny = dx * cl - ex * bl;
    if (d < 0) begin
      nx = -nx;
      ny = -ny;
      d  = -d;
    end
    r.cx = place_axis(ax, nx, wide_u'(d), sat_x);
    r.cy = place_axis(ay, ny, wide_u'(d), sat_y);
    r.st = (sat_x || sat_y) ? ST_SATURATED : ST_VALID;
    return r;
  endfunction

  assign pending_o = centre_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    centre_t want;
    if (!rst_ni) begin
      centre_q.delete();
      mismatches_o <= 0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_i)
        centre_q.push_back(predict_centre(s_axis_tdata_i));
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (centre_q.size() == 0) begin
          if (mismatches_o < 10)
            $display("%0t: result word with nothing expected: x %h y %h st %0d",
                     $realtime, m_axis_tdata_i[31:0], m_axis_tdata_i[63:32], m_axis_tuser_i);
          mismatches_o <= mismatches_o + 1;
        end else begin
          want = centre_q.pop_front();
          if (m_axis_tdata_i[31:0] !== want.cx || m_axis_tdata_i[63:32] !== want.cy ||
              m_axis_tuser_i !== want.st) begin
            if (mismatches_o < 10)
              $display("%0t: mismatch exp x %h y %h st %0d, got x %h y %h st %0d",
                       $realtime, want.cx, want.cy, want.st, m_axis_tdata_i[31:0],
                       m_axis_tdata_i[63:32], m_axis_tuser_i);
            mismatches_o <= mismatches_o + 1;
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== test/tb_triangle_circumcenter_core.sv =====
// Top of the circumcentre core testbench: clock, reset, triangle stimulus and verdict.
`timescale 1ns / 100ps
`default_nettype none
module tb_triangle_circumcenter_core;
  import tcc_pkg::*;

  localparam int N_RANDOM   = 1540;
  localparam int IDLE_LIMIT = 3000;
  localparam int HOLD_CYC   = 400;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [STAT_W-1:0]     m_tuser;
  int                    mismatches;
  int                    pending;
  bit                    hold_req = 1'b0;
  bit                    calm = 1'b0;
  int                    idle_cycles = 0;

  triangle_circumcenter_core uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  tcc_centre_checker checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_i (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_i (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_i  (m_tdata),
    .m_axis_tuser_i  (m_tuser),
    .mismatches_o    (mismatches),
    .pending_o       (pending)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [IN_DATA_W-1:0] tri_word(input int ax, ay, bx, by, cx, cy);
    return {cy[23:0], cx[23:0], by[23:0], bx[23:0], ay[23:0], ax[23:0]};
  endfunction

  function automatic int draw_gap();
    return calm ? 0 : $urandom_range(0, 16);
  endfunction

  // offer one word, hold it until taken; valid only drops when a gap follows
  task automatic send_word(input logic [IN_DATA_W-1:0] w);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= w;
    do @(posedge clk_i); while (!s_tready);
  endtask

  function automatic logic [IN_DATA_W-1:0] random_triangle();
    int ax, ay, bx, by, k, px, py, m, vx, vy;
    logic [IN_DATA_W-1:0] w;
    m = $urandom_range(0, 9);
    if (m < 3) begin
      for (int i = 0; i < 6; i++) w[i*24 +: 24] = 24'($urandom());
    end else if (m < 6) begin
      ax = $urandom_range(0, 4095) - 2048;
      ay = $urandom_range(0, 4095) - 2048;
      for (int i = 0; i < 6; i += 2) begin
        w[i*24 +: 24]     = 24'(ax + $urandom_range(0, 1023) - 512);
        w[(i+1)*24 +: 24] = 24'(ay + $urandom_range(0, 1023) - 512);
      end
    end else begin
      // nearly or exactly collinear: third vertex on the line through the first two
      ax = $urandom_range(0, 2000000) - 1000000;
      ay = $urandom_range(0, 2000000) - 1000000;
      vx = $urandom_range(0, 40000) - 20000;
      vy = $urandom_range(0, 40000) - 20000;
      k  = $urandom_range(0, 6) - 3;
      px = (m == 9) ? 0 : $urandom_range(0, 2) - 1;
      py = (m == 9) ? 0 : $urandom_range(0, 2) - 1;
      bx = ax + vx;
      by = ay + vy;
      w = tri_word(ax, ay, bx, by, ax + k * vx + px, ay + k * vy + py);
    end
    return w;
  endfunction

  // receiver: random stalls per word, one long hold-off on request
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYC) @(posedge clk_i);
        hold_req = 1'b0;
      end
      gap = draw_gap();
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_tready <= 1'b1;
      do @(posedge clk_i); while (!m_tvalid && !hold_req);
    end
  end

  // watchdog on cycles with no word moving on either side
  initial begin
    forever begin
      @(posedge clk_i);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL triangle_circumcenter_core");
        $finish;
      end
    end
  end

  initial begin
    logic [IN_DATA_W-1:0] directed[$];
    int wait_cyc;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed.push_back(tri_word(0, 0, 0, 0, 0, 0));
    directed.push_back(tri_word(0, 0, 1, 0, 0, 1));
    directed.push_back(tri_word(0, 0, -1, 0, 0, -1));
    directed.push_back(tri_word(0, 0, 256, 0, 0, 256));
    directed.push_back(tri_word(5, 7, 5, 7, 100, -3));
    directed.push_back(tri_word(0, 0, 10, 10, 20, 20));
    directed.push_back(tri_word(8388607, 8388607, 8388607, 8388607, 8388607, 8388607));
    directed.push_back(tri_word(-8388608, -8388608, -8388608, -8388608, -8388608, -8388608));
    directed.push_back(tri_word(-8388608, -8388608, 8388607, -8388608, -8388608, 8388607));
    directed.push_back(tri_word(8388607, 8388607, -8388608, 8388607, 8388607, -8388608));
    directed.push_back(tri_word(-8388608, -8388608, 8388607, 8388607, 8388607, 8388606));
    directed.push_back(tri_word(-8388608, 8388607, 8388607, -8388608, 8388606, -8388607));
    directed.push_back(tri_word(8388607, -8388608, -8388608, 8388607, 0, 1));
    directed.push_back(tri_word(0, 0, 3, 0, 0, 4));
    directed.push_back(tri_word(0, 0, 0, 4, 3, 0));
    directed.push_back(tri_word(-1, -1, -1, -1, -1, -1));
    foreach (directed[i]) send_word(directed[i]);

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 100 == 0) calm = ($urandom_range(0, 3) == 0);
      if (n == 700) hold_req = 1'b1;
      send_word(random_triangle());
    end
    s_tvalid <= 1'b0;

    wait_cyc = 0;
    while (pending != 0) @(posedge clk_i);
    while (wait_cyc < 60) begin
      @(posedge clk_i);
      wait_cyc++;
    end
    if (mismatches == 0 && pending == 0) begin
      $display("PASS triangle_circumcenter_core");
    end else begin
      $display("FAIL triangle_circumcenter_core");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+sv
sv/tcc_pkg.sv
sv/tcc_front.sv
sv/tcc_numer.sv
sv/tcc_div.sv
sv/triangle_circumcenter_core.sv
test/tcc_centre_checker.sv
test/tb_triangle_circumcenter_core.sv
